// ===== sv/rne_pkg.sv =====
`default_nettype none

package rne_pkg;

    localparam int unsigned VALUE_W     = 12;
    localparam int unsigned LETTER_W    = 8;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned NUM_PLACES  = 4;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

    localparam logic [LETTER_W-1:0] LETTER_I    = 8'h49;
    localparam logic [LETTER_W-1:0] LETTER_V    = 8'h56;
    localparam logic [LETTER_W-1:0] LETTER_X    = 8'h58;
    localparam logic [LETTER_W-1:0] LETTER_L    = 8'h4C;
    localparam logic [LETTER_W-1:0] LETTER_C    = 8'h43;
    localparam logic [LETTER_W-1:0] LETTER_D    = 8'h44;
    localparam logic [LETTER_W-1:0] LETTER_M    = 8'h4D;
    localparam logic [LETTER_W-1:0] LETTER_NONE = 8'h00;

    // places: 0 units, 1 tens, 2 hundreds, 3 thousands
    localparam logic [1:0] PLACE_UNITS     = 2'd0;
    localparam logic [1:0] PLACE_TENS      = 2'd1;
    localparam logic [1:0] PLACE_HUNDREDS  = 2'd2;
    localparam logic [1:0] PLACE_THOUSANDS = 2'd3;

    typedef enum logic [1:0] {
        ROLE_ONE,
        ROLE_FIVE,
        ROLE_TEN
    } t_role;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } t_fstate;

    typedef enum logic {
        B_IDLE,
        B_EMIT
    } t_bstate;

    // one classified number: decimal digits plus the range flag
    typedef struct packed {
        logic                                 out_of_range;
        logic [NUM_PLACES-1:0][DIGIT_W-1:0]   digits;
    } t_item;

    // number of letters that one decimal digit turns into
    function automatic logic [2:0] digit_len(input logic [DIGIT_W-1:0] d);
        logic [2:0] len;
        case (d)
            4'd0:    len = 3'd0;
            4'd1:    len = 3'd1;
            4'd2:    len = 3'd2;
            4'd3:    len = 3'd3;
            4'd4:    len = 3'd2;
            4'd5:    len = 3'd1;
            4'd6:    len = 3'd2;
            4'd7:    len = 3'd3;
            4'd8:    len = 3'd4;
            4'd9:    len = 3'd2;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    // which letter of the place triple stands at position k of digit d
    function automatic t_role digit_role(input logic [DIGIT_W-1:0] d, input logic [1:0] k);
        t_role r;
        if (d < 4'd4) begin
            r = ROLE_ONE;
        end else if (d == 4'd4) begin
            r = (k == 2'd0) ? ROLE_ONE : ROLE_FIVE;
        end else if (d < 4'd9) begin
            r = (k == 2'd0) ? ROLE_FIVE : ROLE_ONE;
        end else begin
            r = (k == 2'd0) ? ROLE_ONE : ROLE_TEN;
        end
        return r;
    endfunction

    function automatic logic [LETTER_W-1:0] place_letter(input logic [1:0] p, input t_role r);
        logic [LETTER_W-1:0] l;
        case (p)
            PLACE_UNITS: begin
                case (r)
                    ROLE_ONE:  l = LETTER_I;
                    ROLE_FIVE: l = LETTER_V;
                    default:   l = LETTER_X;
                endcase
            end
            PLACE_TENS: begin
                case (r)
                    ROLE_ONE:  l = LETTER_X;
                    ROLE_FIVE: l = LETTER_L;
                    default:   l = LETTER_C;
                endcase
            end
            PLACE_HUNDREDS: begin
                case (r)
                    ROLE_ONE:  l = LETTER_C;
                    ROLE_FIVE: l = LETTER_D;
                    default:   l = LETTER_M;
                endcase
            end
            default: l = LETTER_M;
        endcase
        return l;
    endfunction

endpackage

`default_nettype wire

// ===== sv/rne_front.sv =====
`default_nettype none

module rne_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [rne_pkg::VALUE_W-1:0]   i_value,
    output logic                               o_push,
    output rne_pkg::t_item                     o_item,
    input  wire logic                          i_full
);

    localparam int unsigned CNT_W = $clog2(rne_pkg::VALUE_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(rne_pkg::VALUE_W - 1);
    localparam int unsigned BCD_W = rne_pkg::NUM_PLACES * rne_pkg::DIGIT_W;

    rne_pkg::t_fstate r_state, n_state;
    logic [rne_pkg::VALUE_W-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]            r_bcd, n_bcd;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic                        r_err, n_err;
    logic [BCD_W-1:0]            bcd_adj;
    logic                        accept;
    logic                        bad_value;

    assign accept    = i_valid && o_ready;
    assign bad_value = (i_value == '0) || (i_value > rne_pkg::VALUE_MAX);

    // double dabble: add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int p = 0; p < rne_pkg::NUM_PLACES; p++) begin
            if (r_bcd[p*rne_pkg::DIGIT_W +: rne_pkg::DIGIT_W] >= 4'd5) begin
                bcd_adj[p*rne_pkg::DIGIT_W +: rne_pkg::DIGIT_W] =
                    r_bcd[p*rne_pkg::DIGIT_W +: rne_pkg::DIGIT_W] + 4'd3;
            end else begin
                bcd_adj[p*rne_pkg::DIGIT_W +: rne_pkg::DIGIT_W] =
                    r_bcd[p*rne_pkg::DIGIT_W +: rne_pkg::DIGIT_W];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rne_pkg::F_IDLE: begin
                if (i_valid) begin
                    n_state = bad_value ? rne_pkg::F_PUSH : rne_pkg::F_CONV;
                end
            end
            rne_pkg::F_CONV: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = rne_pkg::F_PUSH;
                end
            end
            rne_pkg::F_PUSH: begin
                if (!i_full) begin
                    n_state = rne_pkg::F_IDLE;
                end
            end
            default: n_state = rne_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == rne_pkg::F_IDLE);
        o_push  = (r_state == rne_pkg::F_PUSH) && !i_full;
        o_item.out_of_range = r_err;
        o_item.digits       = r_bcd;
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        n_cnt = r_cnt;
        n_err = r_err;
        if (accept) begin
            n_bin = i_value;
            n_bcd = '0;
            n_cnt = '0;
            n_err = bad_value;
        end else if (r_state == rne_pkg::F_CONV) begin
            n_bcd = {bcd_adj[BCD_W-2:0], r_bin[rne_pkg::VALUE_W-1]};
            n_bin = {r_bin[rne_pkg::VALUE_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rne_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
        r_err <= n_err;
    end

endmodule

`default_nettype wire

// ===== sv/rne_queue.sv =====
`default_nettype none

module rne_queue #(
    parameter int unsigned DEPTH = rne_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire rne_pkg::t_item  i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output rne_pkg::t_item       o_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    rne_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ===== sv/rne_back.sv =====
`default_nettype none

module rne_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_empty,
    input  wire rne_pkg::t_item                  i_item,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [rne_pkg::LETTER_W-1:0]         o_letter,
    output logic                                 o_last,
    output logic                                 o_out_of_range
);

    rne_pkg::t_bstate r_state, n_state;
    logic [rne_pkg::NUM_PLACES-1:0][rne_pkg::DIGIT_W-1:0] r_digits, n_digits;
    logic [rne_pkg::NUM_PLACES-1:0] r_mask, n_mask;
    logic [1:0]                     r_pos, n_pos;
    logic                           r_err, n_err;

    logic                           r_out_valid, n_out_valid;
    logic [rne_pkg::LETTER_W-1:0]   r_out_letter, n_out_letter;
    logic                           r_out_last, n_out_last;
    logic                           r_out_oor, n_out_oor;

    logic                           out_free;
    logic                           emit;
    logic                           place_done;
    logic                           numeral_done;
    logic [1:0]                     cur_place;
    logic [rne_pkg::DIGIT_W-1:0]    cur_digit;
    logic [2:0]                     cur_len;
    logic [rne_pkg::NUM_PLACES-1:0] load_mask;
    logic [rne_pkg::NUM_PLACES-1:0] rest_mask;
    logic [rne_pkg::LETTER_W-1:0]   cur_letter;

    assign out_free = !r_out_valid || i_ready;

    // highest place still pending is the one being spelled
    always_comb begin
        cur_place = rne_pkg::PLACE_UNITS;
        for (int p = 0; p < rne_pkg::NUM_PLACES; p++) begin
            if (r_mask[p]) begin
                cur_place = 2'(p);
            end
        end
    end

    always_comb begin
        for (int p = 0; p < rne_pkg::NUM_PLACES; p++) begin
            load_mask[p] = (i_item.digits[p] != '0);
        end
    end

    assign cur_digit    = r_digits[cur_place];
    assign cur_len      = rne_pkg::digit_len(cur_digit);
    assign place_done   = ({1'b0, r_pos} == cur_len - 3'd1);
    assign rest_mask    = r_mask & ~(rne_pkg::NUM_PLACES'(1) << cur_place);
    assign numeral_done = r_err || (place_done && (rest_mask == '0));
    assign cur_letter   = rne_pkg::place_letter(cur_place,
                                                rne_pkg::digit_role(cur_digit, r_pos));
    assign emit         = (r_state == rne_pkg::B_EMIT) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            rne_pkg::B_IDLE: begin
                if (!i_empty) begin
                    n_state = rne_pkg::B_EMIT;
                end
            end
            rne_pkg::B_EMIT: begin
                if (out_free && numeral_done) begin
                    n_state = rne_pkg::B_IDLE;
                end
            end
            default: n_state = rne_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop          = (r_state == rne_pkg::B_IDLE) && !i_empty;
        o_valid        = r_out_valid;
        o_letter       = r_out_letter;
        o_last         = r_out_last;
        o_out_of_range = r_out_oor;
    end

    always_comb begin
        n_digits     = r_digits;
        n_mask       = r_mask;
        n_pos        = r_pos;
        n_err        = r_err;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_letter = r_out_letter;
        n_out_last   = r_out_last;
        n_out_oor    = r_out_oor;
        if (o_pop) begin
            n_digits = i_item.digits;
            n_mask   = load_mask;
            n_pos    = '0;
            n_err    = i_item.out_of_range;
        end else if (emit) begin
            n_out_valid  = 1'b1;
            n_out_letter = r_err ? rne_pkg::LETTER_NONE : cur_letter;
            n_out_last   = numeral_done;
            n_out_oor    = r_err;
            if (place_done) begin
                n_mask = rest_mask;
                n_pos  = '0;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rne_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_digits     <= n_digits;
        r_mask       <= n_mask;
        r_pos        <= n_pos;
        r_err        <= n_err;
        r_out_letter <= n_out_letter;
        r_out_last   <= n_out_last;
        r_out_oor    <= n_out_oor;
    end

    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_oor) |-> (r_out_letter == rne_pkg::LETTER_NONE && r_out_last))
        else $error("range error item malformed");

    a_letter_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_oor) |->
            (r_out_letter == rne_pkg::LETTER_I || r_out_letter == rne_pkg::LETTER_V ||
             r_out_letter == rne_pkg::LETTER_X || r_out_letter == rne_pkg::LETTER_L ||
             r_out_letter == rne_pkg::LETTER_C || r_out_letter == rne_pkg::LETTER_D ||
             r_out_letter == rne_pkg::LETTER_M))
        else $error("letter outside roman set");

    a_pending_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rne_pkg::B_EMIT && !r_err) |-> (r_mask != '0))
        else $error("spelling with no pending place");

endmodule

`default_nettype wire

// ===== sv/roman_numeral_encoder.sv =====
`default_nettype none

// Converts a 12-bit binary value into its Roman numeral as ASCII letters, one letter per
// output item, most significant letter first, tlast on the final letter. Values 0 and
// above 3999 give a single item with letter 0, tlast high and tuser high. The front end
// converts each accepted value to decimal digits by shift-and-add-3, one bit per cycle,
// while a rejected value skips the conversion, before the value enters a small queue;
// the back end spells one letter per cycle while the output is not stalled, and returns
// to idle to pick up the next queued number. Since the two halves overlap through the
// queue, the front end can convert the next value while the back end spells the previous
// one. The longest numeral is the 15 letters of 3888.

module roman_numeral_encoder #(
    parameter int unsigned QUEUE_DEPTH = rne_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // [11:0] value, [15:12] zero fill
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,   // [7:0] letter
    output logic             o_m_axis_tlast,
    output logic [0:0]       o_m_axis_tuser    // [0] out_of_range
);

    logic           push, full, pop, empty;
    rne_pkg::t_item front_item, queue_item;
    logic           oor;

    rne_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_value (i_s_axis_tdata[rne_pkg::VALUE_W-1:0]),
        .o_push  (push),
        .o_item  (front_item),
        .i_full  (full)
    );

    rne_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (queue_item)
    );

    rne_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_item         (queue_item),
        .o_pop          (pop),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_letter       (o_m_axis_tdata),
        .o_last         (o_m_axis_tlast),
        .o_out_of_range (oor)
    );

    assign o_m_axis_tuser = oor;

endmodule

`default_nettype wire

// ===== tb/roman_letter_checker.sv =====
`timescale 1ns / 100ps

module roman_letter_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_value_valid,
    input  wire logic        i_value_ready,
    input  wire logic [15:0] i_value_data,    // [11:0] value, [15:12] zero fill
    input  wire logic        i_letter_valid,
    input  wire logic        i_letter_ready,
    input  wire logic [7:0]  i_letter_data,   // [7:0] letter
    input  wire logic        i_letter_last,
    input  wire logic [0:0]  i_letter_flag,   // [0] out_of_range
    output int               o_fail_count,
    output int               o_pending,
    output int               o_letter_count
);

    typedef struct packed {
        logic [rne_pkg::LETTER_W-1:0] letter;
        logic                         last;
        logic                         out_of_range;
    } t_roman_letter;

    t_roman_letter expected_letters[$];
    int            fail_count   = 0;
    int            letter_count = 0;

    function automatic void append_digit(ref logic [rne_pkg::LETTER_W-1:0] spelled[$],
                                         input int d,
                                         input logic [rne_pkg::LETTER_W-1:0] one,
                                         input logic [rne_pkg::LETTER_W-1:0] five,
                                         input logic [rne_pkg::LETTER_W-1:0] ten);
        int k;
        if (d < 4) begin
            for (k = 0; k < d; k++) spelled.push_back(one);
        end else if (d == 4) begin
            spelled.push_back(one);
            spelled.push_back(five);
        end else if (d < 9) begin
            spelled.push_back(five);
            for (k = 5; k < d; k++) spelled.push_back(one);
        end else begin
            spelled.push_back(one);
            spelled.push_back(ten);
        end
    endfunction

    // queues the letters that one accepted value should turn into
    function automatic void spell_numeral(input logic [rne_pkg::VALUE_W-1:0] value);
        int                           v;
        int                           k;
        logic [rne_pkg::LETTER_W-1:0] spelled[$];
        t_roman_letter                item;
        v = value;
        if (v == 0 || v > rne_pkg::VALUE_MAX) begin
            item = '{letter: rne_pkg::LETTER_NONE, last: 1'b1, out_of_range: 1'b1};
            expected_letters.push_back(item);
            return;
        end
        for (k = 0; k < v / 1000; k++) spelled.push_back(rne_pkg::LETTER_M);
        append_digit(spelled, (v / 100) % 10,
                     rne_pkg::LETTER_C, rne_pkg::LETTER_D, rne_pkg::LETTER_M);
        append_digit(spelled, (v / 10) % 10,
                     rne_pkg::LETTER_X, rne_pkg::LETTER_L, rne_pkg::LETTER_C);
        append_digit(spelled, v % 10,
                     rne_pkg::LETTER_I, rne_pkg::LETTER_V, rne_pkg::LETTER_X);
        for (k = 0; k < spelled.size(); k++) begin
            item = '{letter: spelled[k], last: (k == spelled.size() - 1), out_of_range: 1'b0};
            expected_letters.push_back(item);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_roman_letter got;
        t_roman_letter want;
        if (i_rst_n) begin
            if (i_value_valid && i_value_ready) begin
                spell_numeral(i_value_data[rne_pkg::VALUE_W-1:0]);
            end
            if (i_letter_valid && i_letter_ready) begin
                got = '{letter: i_letter_data, last: i_letter_last,
                        out_of_range: i_letter_flag[0]};
                letter_count++;
                if (expected_letters.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: unexpected item letter %h last %b out_of_range %b",
                                 $realtime, got.letter, got.last, got.out_of_range);
                    end
                end else begin
                    want = expected_letters.pop_front();
                    if (got != want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: exp/act letter %h/%h last %b/%b oor %b/%b",
                                     $realtime, want.letter, got.letter, want.last,
                                     got.last, want.out_of_range, got.out_of_range);
                        end
                    end
                end
            end
        end
        o_fail_count   <= fail_count;
        o_pending      <= expected_letters.size();
        o_letter_count <= letter_count;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int NUM_DIRECTED = 25;
    localparam int NUM_RANDOM   = 445;
    localparam int MAX_IDLE     = 18;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    int fail_count;
    int pending;
    int letter_count;

    logic [rne_pkg::VALUE_W-1:0] directed_values [0:NUM_DIRECTED-1] = '{
        12'd0, 12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd3888, 12'd4, 12'd9,
        12'd5, 12'd8, 12'd40, 12'd90, 12'd400, 12'd900, 12'd1000, 12'd2000,
        12'd3000, 12'd1444, 12'd1999, 12'd2888, 12'd3494, 12'd10, 12'd2048,
        12'd7, 12'd3333
    };

    roman_numeral_encoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tuser  (m_tuser)
    );

    roman_letter_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_value_valid  (s_tvalid),
        .i_value_ready  (s_tready),
        .i_value_data   (s_tdata),
        .i_letter_valid (m_tvalid),
        .i_letter_ready (m_tready),
        .i_letter_data  (m_tdata),
        .i_letter_last  (m_tlast),
        .i_letter_flag  (m_tuser),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_letter_count (letter_count)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // mostly legal values, a share of long numerals and a share of rejected ones
    function automatic logic [rne_pkg::VALUE_W-1:0] pick_value();
        int sel;
        int v;
        int p;
        int d;
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
            v = $urandom_range(1, 3999);
        end else if (sel < 72) begin
            v = $urandom_range(0, 3);
            for (p = 0; p < 3; p++) begin
                case ($urandom_range(0, 5))
                    0:       d = 3;
                    1:       d = 7;
                    2:       d = 8;
                    default: d = $urandom_range(0, 9);
                endcase
                v = v * 10 + d;
            end
            if (v == 0) v = 3888;
        end else if (sel < 84) begin
            v = $urandom_range(1, 20);
        end else if (sel < 90) begin
            v = 0;
        end else begin
            v = $urandom_range(4000, 4095);
        end
        return v[rne_pkg::VALUE_W-1:0];
    endfunction

    initial begin : stimulus
        int                          n;
        int                          gap;
        int                          guard;
        int                          rejected;
        logic                        send_calm;
        logic [rne_pkg::VALUE_W-1:0] value;
        rejected  = 0;
        send_calm = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (n = 0; n < NUM_DIRECTED + NUM_RANDOM; n++) begin
            value = (n < NUM_DIRECTED) ? directed_values[n] : pick_value();
            if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
            gap = send_calm ? 0 : $urandom_range(0, MAX_IDLE);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {4'b0, value};
            @(posedge i_clk);
            while (!s_tready) @(posedge i_clk);
            if (value == 0 || value > rne_pkg::VALUE_MAX) rejected++;
        end
        s_tvalid <= 1'b0;
        // let the letters of the last accepted value reach the pending count
        @(posedge i_clk);
        guard = 0;
        while (pending != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
        $display("%0d values sent (%0d out of range), %0d letters checked, %0d still owed",
                 NUM_DIRECTED + NUM_RANDOM, rejected, letter_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // output side stalls at random, with calm stretches of tready held high
    initial begin : drain
        int   stall;
        logic take_calm;
        take_calm = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 29) == 0) take_calm = !take_calm;
            stall = take_calm ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        #15_000_000;
        $display("timeout with %0d letters still owed", pending);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
